### rtl/bph_pkg.sv
// Package: shared constants, codes and controller/datapath interface types for the probe table.
`timescale 1ns / 1ps

package bph_pkg;

   localparam int DEF_TABLE_ENTRIES = 1024;
   localparam int DEF_PROBE_LIMIT   = 3;
   localparam int DEF_VALUE_BITS    = 32;

   localparam int HASH_BITS  = 32;
   localparam int MOD_STEPS  = 3;
   localparam int MOD_CNT_W  = $clog2(MOD_STEPS);
   localparam int WORD_BITS  = 32;

   localparam logic [HASH_BITS-1:0] MIX_C1 = 32'h85eb_ca6b;
   localparam logic [HASH_BITS-1:0] MIX_C2 = 32'hc2b2_ae35;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic accept;
      logic mix1;
      logic mix2;
      logic mix3;
      logic mod_step;
      logic mem_rd;
      logic wr_ins;
      logic wr_rm;
      logic found;
      logic done;
      logic advance;
      logic clr_step;
      logic out_load;
   } bph_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       hit;
      logic       free;
      logic       clr_last;
      logic       out_free;
   } bph_sts_type;

endpackage

### rtl/bounded_probe_hash_table.sv
// Top level: key/value table with murmur3-finalizer hashing and a bounded linear probe window.
// Usage:
//  - req channel carries one word per operation: req_cmd (0 lookup, 1 insert, 2 remove),
//    req_key and req_payload (stored on insert only). Code 3 answers "not found".
//  - rsp channel returns exactly one word per request: rsp_status (0 done/found,
//    1 not found, 2 window full) and rsp_found_value (lookup hit only, else zero).
//  - One operation is in flight at a time; req_ready is high only while the block idles.
//  - Steps from accept to rsp_valid: the hash steps S_MIX1, S_MIX2 and S_MIX3, then per probed
//    slot a read and then a check/write on the single-port table, then the output register load.
//    Code 3 leaves after S_MIX1 for the output load. A table size that is not a power of two
//    adds the S_MOD reciprocal-multiply remainder steps to every hashed operation.
//  - Reset starts a clearing pass that writes every valid bit to zero, one slot a cycle;
//    req_ready stays low until the last slot is cleared.
//  - The result sits in an output register; the next request is taken while it waits.
//    A finished operation holds in the controller until that register frees up.
`timescale 1ns / 1ps

module bounded_probe_hash_table import bph_pkg::*; #(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int PROBE_LIMIT   = DEF_PROBE_LIMIT,
   parameter int VALUE_BITS    = DEF_VALUE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [WORD_BITS-1:0] req_key,
   input  logic [WORD_BITS-1:0] req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [WORD_BITS-1:0] rsp_found_value
);

   bph_cmd_type ctl;
   bph_sts_type sts;

   bph_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PROBE_LIMIT   (PROBE_LIMIT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   bph_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .VALUE_BITS    (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

endmodule

### rtl/bph_dp.sv
// Datapath: hash pipeline, slot index reduction, table memory, result and output registers.
`timescale 1ns / 1ps

module bph_dp import bph_pkg::*; #(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int VALUE_BITS    = DEF_VALUE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bph_cmd_type          ctl,
   output bph_sts_type          sts,
   input  logic [1:0]           req_cmd,
   input  logic [WORD_BITS-1:0] req_key,
   input  logic [WORD_BITS-1:0] req_payload,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [WORD_BITS-1:0] rsp_found_value
);

   localparam int  IDX_W      = $clog2(TABLE_ENTRIES);
   localparam int  REM_W      = IDX_W + 1;
   localparam int  STORE_BITS = (VALUE_BITS < WORD_BITS) ? VALUE_BITS : WORD_BITS;
   localparam bit  IS_POW2    = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [REM_W-1:0] ENT_REM  = REM_W'(TABLE_ENTRIES);
   localparam logic [HASH_BITS-1:0] RECIP =
      HASH_BITS'((64'd1 << HASH_BITS) / 64'(TABLE_ENTRIES));

   logic [1:0]             cmd_ff;
   logic [WORD_BITS-1:0]   key_ff;
   logic [STORE_BITS-1:0]  pay_ff;
   logic [HASH_BITS-1:0]   m1_ff, m2_ff, hsh_ff;
   logic [HASH_BITS-1:0]   x1, x2, m1_in, m2_in, hash;
   logic [IDX_W-1:0]       idx_ff, clr_ff, addr;
   logic [2*HASH_BITS-1:0] recip_prod;
   logic [HASH_BITS-1:0]   quo_ff;
   logic [REM_W-1:0]       quo_n, rem_ff, rem_fix;
   logic [1:0]             st_ff;
   logic [STORE_BITS-1:0]  val_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic [WORD_BITS-1:0]   rsp_value_ff;

   logic                  mem_vld [TABLE_ENTRIES];
   logic [WORD_BITS-1:0]  mem_key [TABLE_ENTRIES];
   logic [STORE_BITS-1:0] mem_val [TABLE_ENTRIES];
   logic                  rd_vld_ff;
   logic [WORD_BITS-1:0]  rd_key_ff;
   logic [STORE_BITS-1:0] rd_val_ff;

   assign x1    = key_ff ^ (key_ff >> 16);
   assign m1_in = x1 * MIX_C1;
   assign x2    = m1_ff ^ (m1_ff >> 13);
   assign m2_in = x2 * MIX_C2;
   assign hash  = m2_ff ^ (m2_ff >> 16);

   // hash mod TABLE_ENTRIES: reciprocal quotient is short by at most one,
   // so the estimate stays below twice the table size and one subtract fixes it
   assign recip_prod = (2*HASH_BITS)'(hsh_ff) * (2*HASH_BITS)'(RECIP);
   assign quo_n      = REM_W'(quo_ff[REM_W-1:0] * ENT_REM);
   assign rem_fix    = (rem_ff >= ENT_REM) ? (rem_ff - ENT_REM) : rem_ff;

   assign addr = ctl.clr_step ? clr_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
         pay_ff <= req_payload[STORE_BITS-1:0];
      end
      if (ctl.mix1) begin
         m1_ff <= m1_in;
      end
      if (ctl.mix2) begin
         m2_ff <= m2_in;
      end
      if (ctl.mix3) begin
         hsh_ff <= hash;
         idx_ff <= IS_POW2 ? hash[IDX_W-1:0] : '0;
      end else if (ctl.mod_step) begin
         idx_ff <= rem_fix[IDX_W-1:0];
      end else if (ctl.advance) begin
         idx_ff <= (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
      end
      if (ctl.mod_step) begin
         quo_ff <= recip_prod[2*HASH_BITS-1:HASH_BITS];
         rem_ff <= hsh_ff[REM_W-1:0] - quo_n;
      end
      if (ctl.accept) begin
         st_ff  <= (req_cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
         val_ff <= '0;
      end else if (ctl.found) begin
         st_ff  <= ST_DONE;
         val_ff <= rd_val_ff;
      end else if (ctl.done) begin
         st_ff <= ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clr_step || ctl.wr_ins || ctl.wr_rm) begin
         mem_vld[addr] <= ctl.wr_ins;
      end
      if (ctl.wr_ins) begin
         mem_key[addr] <= key_ff;
         mem_val[addr] <= pay_ff;
      end
      if (ctl.mem_rd) begin
         rd_vld_ff <= mem_vld[addr];
         rd_key_ff <= mem_key[addr];
         rd_val_ff <= mem_val[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctl.clr_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_status_ff <= st_ff;
         rsp_value_ff  <= WORD_BITS'(val_ff);
      end
   end

   assign sts.cmd      = cmd_ff;
   assign sts.hit      = rd_vld_ff && (rd_key_ff == key_ff);
   assign sts.free     = !rd_vld_ff;
   assign sts.clr_last = (clr_ff == IDX_LAST);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

endmodule

### rtl/bph_ctrl.sv
// Controller: sequences clearing, hashing, index reduction and the probe walk.
`timescale 1ns / 1ps

module bph_ctrl import bph_pkg::*; #(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int PROBE_LIMIT   = DEF_PROBE_LIMIT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  bph_sts_type sts,
   output bph_cmd_type ctl
);

   localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
   localparam int PRB_W   = $clog2(PROBE_LIMIT + 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MIX1  = 4'd2;
   localparam logic [3:0] S_MIX2  = 4'd3;
   localparam logic [3:0] S_MIX3  = 4'd4;
   localparam logic [3:0] S_MOD   = 4'd5;
   localparam logic [3:0] S_READ  = 4'd6;
   localparam logic [3:0] S_CHECK = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [PRB_W-1:0]     prb_ff, prb_in;
   logic [MOD_CNT_W-1:0] mod_ff, mod_in;
   logic                 prb_last;

   assign prb_last  = (prb_ff == PRB_W'(PROBE_LIMIT - 1));
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      prb_in   = prb_ff;
      mod_in   = mod_ff;
      ctl      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               prb_in     = '0;
               mod_in     = '0;
               state_in   = S_MIX1;
            end
         end
         S_MIX1: begin
            ctl.mix1 = 1'b1;
            state_in = (sts.cmd == CMD_LOOKUP || sts.cmd == CMD_INSERT ||
                        sts.cmd == CMD_REMOVE) ? S_MIX2 : S_DONE;
         end
         S_MIX2: begin
            ctl.mix2 = 1'b1;
            state_in = S_MIX3;
         end
         S_MIX3: begin
            ctl.mix3 = 1'b1;
            state_in = IS_POW2 ? S_READ : S_MOD;
         end
         S_MOD: begin
            ctl.mod_step = 1'b1;
            mod_in       = mod_ff + 1'b1;
            if (mod_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            ctl.mem_rd = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            state_in = prb_last ? S_DONE : S_READ;
            case (sts.cmd)
               CMD_LOOKUP: begin
                  if (sts.hit) begin
                     ctl.found = 1'b1;
                     state_in  = S_DONE;
                  end
               end
               CMD_INSERT: begin
                  if (sts.free) begin
                     ctl.wr_ins = 1'b1;
                     ctl.done   = 1'b1;
                     state_in   = S_DONE;
                  end
               end
               CMD_REMOVE: begin
                  if (sts.hit) begin
                     ctl.wr_rm = 1'b1;
                     ctl.done  = 1'b1;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
            if (state_in == S_READ) begin
               ctl.advance = 1'b1;
               prb_in      = prb_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         prb_ff   <= '0;
         mod_ff   <= '0;
      end else begin
         state_ff <= state_in;
         prb_ff   <= prb_in;
         mod_ff   <= mod_in;
      end
   end

endmodule

### rtl/bph_chk.sv
// Checker: port-level assertions for the probe table, bound to the top level.
`timescale 1ns / 1ps

module bph_chk import bph_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_status,
   input logic [WORD_BITS-1:0] rsp_found_value
);

   // clearing pass keeps both sides quiet right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request or response active right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_found_value))
      else $error("stalled response word changed");

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_MISS ||
                     rsp_status == ST_FULL))
      else $error("undefined response status");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_found_value == '0)
      else $error("nonzero value on a miss or full response");

endmodule

bind bounded_probe_hash_table bph_chk u_bph_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_found_value (rsp_found_value)
);
